### hw/rtl/gbcm_pkg.sv
`timescale 1ns / 1ps

package gbcm_pkg;

	// config register indexes
	typedef enum logic [1:0] {
		REG_GAMMA    = 2'd0,
		REG_BRIGHT   = 2'd1,
		REG_CONTRAST = 2'd2,
		REG_UNUSED   = 2'd3
	} gbcm_reg_t;

	// fixed point for 8 - log2(v): 4 integer bits (8.0 at v = 1), 36 fraction bits
	localparam int FRAC_BITS = 36;
	localparam int NLW       = FRAC_BITS + 4;
	// gamma times log term, and the compare width with headroom
	localparam int PW        = NLW + 9;
	localparam int AW        = PW + 1;
	// tie tolerance, well above the summed rounding error of the table terms
	localparam logic [AW-1:0] EPS = AW'(1024);

	localparam int SLW = 18;  // slope, signed
	localparam int RCW = 25;  // reciprocal of the contrast divisor
	localparam int RC_SHIFT = 24;

	typedef logic [NLW-1:0]        nlog_tab_t  [256];
	typedef logic signed [SLW-1:0] slope_tab_t [256];
	typedef logic [RCW-1:0]        recip_tab_t [256];

	// shift and subtract division, used at elaboration only
	function automatic longint unsigned udiv_f(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 40; i >= 0; i--) begin
			r = (r << 1) | ((n >> i) & 64'd1);
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic nlog_tab_t nlog_build();
		nlog_tab_t t;
		real r;
		t[0] = '0;
		for (int v = 1; v < 256; v++) begin
			r = (8.0 - $ln(real'(v)) * 1.4426950408889634) * (2.0 ** FRAC_BITS);
			t[v] = NLW'(longint'(r));
		end
		return t;
	endfunction

	// indexed by the contrast byte; divisor is 128 - contrast, 1..256
	function automatic slope_tab_t slope_build();
		slope_tab_t t;
		longint unsigned den;
		for (int c = 0; c < 256; c++) begin
			den = longint'(128 - ((c >= 128) ? (c - 256) : c));
			t[c] = SLW'(longint'(udiv_f(64'd65536, den)) - 256);
		end
		return t;
	endfunction

	function automatic recip_tab_t recip_build();
		recip_tab_t t;
		longint unsigned den;
		for (int c = 0; c < 256; c++) begin
			den = longint'(128 - ((c >= 128) ? (c - 256) : c));
			t[c] = RCW'(udiv_f((64'd1 << RC_SHIFT) + den - 64'd1, den));
		end
		return t;
	endfunction

	localparam nlog_tab_t  NLOG_TAB  = nlog_build();
	localparam slope_tab_t SLOPE_TAB = slope_build();
	localparam recip_tab_t RECIP_TAB = recip_build();

endpackage

### hw/rtl/gamma_brightness_contrast_map.sv
`timescale 1ns / 1ps

// gamma / contrast / brightness map for an 8-bit pixel stream
//
// input channel s_*: one pixel per word, s_tdata[7:0] = pixel_in
// output channel m_*: one corrected pixel per word, m_tdata[7:0] = pixel_out
// config channel cfg_*: cfg_index 0 gamma_percent, 1 brightness, 2 contrast;
// other indexes are dropped. cfg_ready is always high. write only while idle.
//
// throughput is one pixel per clock while the receiver does not stall: the gamma
// curve is an 8-stage bitwise search, one result bit per stage, each stage a table
// lookup, a 9-bit by 40-bit multiply and a compare in log domain. two more stages
// do the contrast slope and the add.
//
// reset clears all valid bits and loads gamma 100, brightness 0, contrast 0.
// when the receiver stalls with a word waiting, the whole pipe holds and
// s_tready drops; nothing is lost or repeated. while the output word is
// taken, a new input word is accepted in the same cycle.
module gamma_brightness_contrast_map
	import gbcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// config write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	// pixel in
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel_in
	// pixel out
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] pixel_out
);

	localparam int NSRCH = 8;

	// config registers
	logic [8:0] gamma_q;
	logic [7:0] bright_cfg_q;
	logic [7:0] contrast_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q      <= 9'd100;
			bright_cfg_q <= '0;
			contrast_q   <= '0;
		end else if (cfg_valid) begin
			case (gbcm_reg_t'(cfg_index))
				REG_GAMMA:    gamma_q      <= cfg_data;
				REG_BRIGHT:   bright_cfg_q <= cfg_data[7:0];
				REG_CONTRAST: contrast_q   <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	// gamma of zero acts as one
	logic [8:0] g_eff;
	assign g_eff = (gamma_q == '0) ? 9'd1 : gamma_q;

	// derived contrast terms, settle in the cycle after a write, long before use
	logic signed [SLW-1:0] slope_q;
	logic signed [16:0]    bright_q;
	logic [7:0]            b_mag;
	logic [15:0]           b_num;
	logic [RCW+15:0]       b_prod;
	logic [16:0]           b_quo;

	assign b_mag  = bright_cfg_q[7] ? 8'(-bright_cfg_q) : bright_cfg_q;
	assign b_num  = {b_mag, 8'd0};
	assign b_prod = (RCW+16)'(b_num) * (RCW+16)'(RECIP_TAB[contrast_q]);
	assign b_quo  = b_prod[RC_SHIFT +: 17];

	always_ff @(posedge clk) begin
		slope_q  <= SLOPE_TAB[contrast_q];
		bright_q <= bright_cfg_q[7] ? -$signed(b_quo) : $signed(b_quo);
	end

	// global advance: the pipe moves unless the output word is stuck
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: target a = 100 * (8 - log2 x); black input gets an unreachable target
	logic [AW-1:0] a_s   [1:NSRCH];
	logic [7:0]    y_s   [1:NSRCH+1];
	logic          vld_s [1:NSRCH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[1] <= (s_tdata == '0) ? '1 :
				AW'(NLOG_TAB[s_tdata]) * AW'(100);
			y_s[1] <= '0;
		end
	end

	// stages 2..9: set one bit of y per stage, msb first.
	// keep the bit when gamma * (8 - log2 cand) >= a, i.e. (cand/256)^g <= (x/256)^100
	for (genvar i = 0; i < NSRCH; i++) begin : g_srch
		logic [7:0]    cand;
		logic [PW-1:0] gprod;
		logic          keep;

		assign cand  = y_s[i+1] | 8'(1 << (NSRCH - 1 - i));
		assign gprod = PW'(g_eff) * PW'(NLOG_TAB[cand]);
		assign keep  = (AW'(gprod) + EPS) >= a_s[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+2] <= 1'b0;
			end else if (en) begin
				vld_s[i+2] <= vld_s[i+1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[i+2] <= keep ? cand : y_s[i+1];
			end
		end

		// the target rides along until the last search stage
		if (i < NSRCH - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					a_s[i+2] <= a_s[i+1];
				end
			end
		end
	end

	// stage 10: slope times (y - 128)
	logic signed [26:0] prod_s10;
	logic               vld_s10;
	logic signed [8:0]  yc;

	assign yc = $signed({1'b0, y_s[NSRCH+1]}) - 9'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s[NSRCH+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s10 <= 27'(slope_q) * 27'(yc);
		end
	end

	// stage 11: floor shift, offsets, saturate; this is the output register
	logic signed [19:0] z;
	logic [7:0]         z_sat;

	assign z = 20'(prod_s10 >>> 8) + 20'sd128 + 20'(bright_q);
	always_comb begin
		if (z < 0) begin
			z_sat = 8'd0;
		end else if (z > 20'sd255) begin
			z_sat = 8'd255;
		end else begin
			z_sat = z[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= z_sat;
		end
	end

endmodule

### hw/rtl/gbcm_chk.sv
`timescale 1ns / 1ps

module gbcm_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_ready,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

	// input side opens exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// config port never back-pressures
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config ready low");

	// a pipe just out of reset shows no word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid at reset");

endmodule

bind gamma_brightness_contrast_map gbcm_chk u_gbcm_chk (.*);
